[hw/rtl/gpdc_pkg.sv]
// Shared types, constants and helper functions for the GNSS power duty cycler.
// No dependencies; compiled first.
`default_nettype none

package gpdc_pkg;

   localparam int unsigned TIME_W    = 32;
   localparam int unsigned YEAR_W    = 12;
   localparam int unsigned MONTH_W   = 4;
   localparam int unsigned DAY_W     = 5;
   localparam int unsigned HOUR_W    = 5;
   localparam int unsigned MINUTE_W  = 6;
   localparam int unsigned SECOND_W  = 6;
   localparam int unsigned EVENT_W   = 3;
   localparam int unsigned INTERVAL_W = 16;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned HMS_W      = 17;
   localparam int unsigned MDAY_W     = 9;

   localparam logic [TIME_W-1:0] SYNC_PERIOD_MS   = 32'd86339000;
   localparam logic [TIME_W-1:0] NOFIX_TIMEOUT_MS = 32'd900000;
   localparam logic [TIME_W-1:0] DEBOUNCE_MS      = 32'd60000;
   localparam logic [9:0]        MS_PER_S         = 10'd1000;

   localparam logic [TIME_W-1:0] EPOCH_DAY_OFFSET = 32'd719468;
   localparam logic [TIME_W-1:0] DAYS_PER_YEAR    = 32'd365;
   localparam logic [TIME_W-1:0] SEC_PER_DAY      = 32'd86400;
   localparam logic [HMS_W-1:0]  SEC_PER_HOUR     = 17'd3600;
   localparam logic [HMS_W-1:0]  SEC_PER_MIN      = 17'd60;
   localparam logic [12:0]       RECIP_100        = 13'd5243;
   localparam int unsigned       RECIP_SHIFT      = 19;

   localparam logic [EVENT_W-1:0] EV_NONE        = 3'd0;
   localparam logic [EVENT_W-1:0] EV_WOKE        = 3'd1;
   localparam logic [EVENT_W-1:0] EV_OFF_LOCATED = 3'd2;
   localparam logic [EVENT_W-1:0] EV_OFF_TIMEOUT = 3'd3;
   localparam logic [EVENT_W-1:0] EV_OFF_SYNCED  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_AUTO_LOCATION   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_UPDATE_INTERVAL = 1'b1;

   typedef struct packed {
      logic                  power_enable;
      logic [EVENT_W-1:0]    power_event;
      logic                  clock_set;
      logic                  location_capture;
      logic [YEAR_W-1:0]     year;
      logic [MONTH_W-1:0]    month;
      logic [DAY_W-1:0]      day;
      logic [HOUR_W-1:0]     hour;
      logic [MINUTE_W-1:0]   minute;
      logic [SECOND_W-1:0]   second;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIV,
      BK_DAYS,
      BK_SCALE,
      BK_DONE
   } back_state_type;

   // days from March 1 to the first of the month, March-based year
   function automatic logic [MDAY_W-1:0] month_days_before(input logic [MONTH_W-1:0] mo);
      logic [MDAY_W-1:0] d;
      case (mo)
         4'd0:    d = 9'd275;
         4'd1:    d = 9'd306;
         4'd2:    d = 9'd337;
         4'd3:    d = 9'd0;
         4'd4:    d = 9'd31;
         4'd5:    d = 9'd61;
         4'd6:    d = 9'd92;
         4'd7:    d = 9'd122;
         4'd8:    d = 9'd153;
         4'd9:    d = 9'd184;
         4'd10:   d = 9'd214;
         4'd11:   d = 9'd245;
         4'd12:   d = 9'd275;
         4'd13:   d = 9'd306;
         4'd14:   d = 9'd337;
         4'd15:   d = 9'd367;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/gpdc_if.sv]
// Valid/ready channel interfaces for tick requests and per-tick responses.
// Depends on gpdc_pkg.
`default_nettype none

interface gpdc_req_if;
   import gpdc_pkg::*;
   logic                valid;
   logic                ready;
   logic [TIME_W-1:0]   now_ms;
   logic                fix_valid;
   logic                datetime_valid;
   logic [YEAR_W-1:0]   year;
   logic [MONTH_W-1:0]  month;
   logic [DAY_W-1:0]    day;
   logic [HOUR_W-1:0]   hour;
   logic [MINUTE_W-1:0] minute;
   logic [SECOND_W-1:0] second;

   modport source (output valid, now_ms, fix_valid, datetime_valid, year, month, day,
                   hour, minute, second, input ready);
   modport sink (input valid, now_ms, fix_valid, datetime_valid, year, month, day,
                 hour, minute, second, output ready);
endinterface

interface gpdc_rsp_if;
   import gpdc_pkg::*;
   logic               valid;
   logic               ready;
   logic               power_enable;
   logic [EVENT_W-1:0] power_event;
   logic               clock_set;
   logic [TIME_W-1:0]  epoch_seconds;
   logic               location_capture;

   modport source (output valid, power_enable, power_event, clock_set, epoch_seconds,
                   location_capture, input ready);
   modport sink (input valid, power_enable, power_event, clock_set, epoch_seconds,
                 location_capture, output ready);
endinterface

`default_nettype wire

[hw/rtl/gpdc_front.sv]
// Front end: accepts ticks, holds config and power/sync/location state, classifies ticks.
// Depends on gpdc_pkg and gpdc_if.
`default_nettype none

module gpdc_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   gpdc_req_if.sink                              req_chan,
   input  wire logic                             csr_write_enable,
   input  wire logic [gpdc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [gpdc_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  wire gpdc_pkg::queue_status_type       q_status,
   output logic                                  push,
   output gpdc_pkg::job_type                     push_job
);
   import gpdc_pkg::*;

   logic                  auto_ff;
   logic [INTERVAL_W-1:0] interval_s_ff;
   logic                  powered_ff, powered_in;
   logic [TIME_W-1:0]     pos_ff, pos_in;
   logic [TIME_W-1:0]     sync_ff, sync_in;
   logic [TIME_W-1:0]     loc_ff, loc_in;

   logic [TIME_W-1:0]     interval_ms;
   logic                  interval_nz;
   logic [TIME_W-1:0]     since_on, since_sync, since_loc;
   logic                  synced_recently;
   logic                  loc_due;
   logic [EVENT_W-1:0]    event_w;
   logic                  clk_set, cap;

   assign req_chan.ready = !q_status.full;
   assign push           = req_chan.valid && !q_status.full;

   always_comb begin
      interval_ms     = TIME_W'(interval_s_ff) * TIME_W'(MS_PER_S);
      interval_nz     = (interval_s_ff != '0);
      since_on        = req_chan.now_ms - pos_ff;
      since_sync      = req_chan.now_ms - sync_ff;
      since_loc       = req_chan.now_ms - loc_ff;
      synced_recently = (since_sync < DEBOUNCE_MS) && (sync_ff != '0);
      loc_due         = since_loc > interval_ms;

      powered_in = powered_ff;
      pos_in     = pos_ff;
      sync_in    = sync_ff;
      loc_in     = loc_ff;
      event_w    = EV_NONE;
      clk_set    = 1'b0;
      cap        = 1'b0;

      if (auto_ff) begin
         if (interval_nz) begin
            if (powered_ff) begin
               if (loc_ff > pos_ff) begin
                  powered_in = 1'b0;
                  event_w    = EV_OFF_LOCATED;
               end else if (since_on > NOFIX_TIMEOUT_MS) begin
                  powered_in = 1'b0;
                  event_w    = EV_OFF_TIMEOUT;
               end
            end else if (loc_due) begin
               powered_in = 1'b1;
               pos_in     = req_chan.now_ms;
               event_w    = EV_WOKE;
            end
         end else if (!powered_ff) begin
            powered_in = 1'b1;
            pos_in     = req_chan.now_ms;
            event_w    = EV_WOKE;
         end
      end else begin
         if (powered_ff) begin
            if (synced_recently) begin
               powered_in = 1'b0;
               event_w    = EV_OFF_SYNCED;
            end else if (since_on > NOFIX_TIMEOUT_MS) begin
               powered_in = 1'b0;
               event_w    = EV_OFF_TIMEOUT;
            end
         end else if (since_sync > SYNC_PERIOD_MS) begin
            powered_in = 1'b1;
            pos_in     = req_chan.now_ms;
            event_w    = EV_WOKE;
         end
      end

      if (powered_in && req_chan.fix_valid) begin
         if (req_chan.datetime_valid && !synced_recently) begin
            clk_set = 1'b1;
            sync_in = req_chan.now_ms;
         end
         if (auto_ff && ((interval_nz && loc_due) || (!interval_nz && loc_ff == '0))) begin
            cap    = 1'b1;
            loc_in = req_chan.now_ms;
         end
      end

      push_job.power_enable     = powered_in;
      push_job.power_event      = event_w;
      push_job.clock_set        = clk_set;
      push_job.location_capture = cap;
      push_job.year             = req_chan.year;
      push_job.month            = req_chan.month;
      push_job.day              = req_chan.day;
      push_job.hour             = req_chan.hour;
      push_job.minute           = req_chan.minute;
      push_job.second           = req_chan.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_ff       <= 1'b0;
         interval_s_ff <= '0;
         powered_ff    <= 1'b1;
         pos_ff        <= '0;
         sync_ff       <= '0;
         loc_ff        <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_AUTO_LOCATION:   auto_ff       <= csr_write_data[0];
               CSR_UPDATE_INTERVAL: interval_s_ff <= csr_write_data[INTERVAL_W-1:0];
               default: ;
            endcase
         end
         if (push) begin
            powered_ff <= powered_in;
            pos_ff     <= pos_in;
            sync_ff    <= sync_in;
            loc_ff     <= loc_in;
         end
      end
   end

endmodule

`default_nettype wire

[hw/rtl/gpdc_queue.sv]
// Short FIFO of classified ticks between the front end and the back end.
// Depends on gpdc_pkg.
`default_nettype none

module gpdc_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire gpdc_pkg::job_type           push_job,
   input  wire logic                        pop,
   output gpdc_pkg::job_type                pop_job,
   output gpdc_pkg::queue_status_type       status
);
   import gpdc_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_job      = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/gpdc_back.sv]
// Back end: converts the UTC date to Unix seconds over three steps, drives the response register.
// Depends on gpdc_pkg and gpdc_if.
`default_nettype none

module gpdc_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire gpdc_pkg::queue_status_type  q_status,
   input  wire gpdc_pkg::job_type           pop_job,
   output logic                             pop,
   gpdc_rsp_if.source                       rsp_chan
);
   import gpdc_pkg::*;

   back_state_type        state_ff, state_in;
   job_type               job_ff;
   logic                  out_valid_ff, out_valid_in;
   logic                  load_out;

   logic [TIME_W-1:0]     y365_ff, y365_in;
   logic [9:0]            q4_ff, q4_in;
   logic [5:0]            q100_ff, q100_in;
   logic [MDAY_W-1:0]     mday_ff, mday_in;
   logic [HMS_W-1:0]      hms_ff, hms_in;
   logic [TIME_W-1:0]     days_ff, days_in;
   logic [TIME_W-1:0]     epoch_ff, epoch_in;

   logic                  early_month, y_neg;
   logic [YEAR_W-1:0]     y_u;
   logic [24:0]           q100_prod;
   logic [22:0]           q400_prod;
   logic [3:0]            q400;

   // step one: year split, divide by 100, time of day
   always_comb begin
      early_month = (job_ff.month <= MONTH_W'(2));
      y_neg       = early_month && (job_ff.year == '0);
      y_u         = y_neg ? '0 : (early_month ? job_ff.year - 1'b1 : job_ff.year);
      y365_in     = y_neg ? ('0 - DAYS_PER_YEAR) : TIME_W'(y_u) * DAYS_PER_YEAR;
      q4_in       = y_u[YEAR_W-1:2];
      q100_prod   = 25'(y_u) * 25'(RECIP_100);
      q100_in     = q100_prod[24:RECIP_SHIFT];
      mday_in     = month_days_before(job_ff.month);
      hms_in      = HMS_W'(job_ff.hour) * SEC_PER_HOUR + HMS_W'(job_ff.minute) * SEC_PER_MIN
                    + HMS_W'(job_ff.second);
   end

   // step two: day count; step three: scale to seconds
   always_comb begin
      q400_prod = 23'(q4_ff) * 23'(RECIP_100);
      q400      = q400_prod[22:RECIP_SHIFT];
      days_in   = y365_ff + TIME_W'(q4_ff) - TIME_W'(q100_ff) + TIME_W'(q400)
                  + TIME_W'(mday_ff) + TIME_W'(job_ff.day) - TIME_W'(1) - EPOCH_DAY_OFFSET;
      epoch_in  = days_ff * SEC_PER_DAY + TIME_W'(hms_ff);
   end

   always_comb begin
      state_in     = state_ff;
      pop          = 1'b0;
      load_out     = 1'b0;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               state_in = pop_job.clock_set ? BK_DIV : BK_DONE;
            end
         end
         BK_DIV:   state_in = BK_DAYS;
         BK_DAYS:  state_in = BK_SCALE;
         BK_SCALE: state_in = BK_DONE;
         BK_DONE: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               load_out     = 1'b1;
               out_valid_in = 1'b1;
               state_in     = BK_IDLE;
            end
         end
         default:  state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= pop_job;
      end
      if (state_ff == BK_DIV) begin
         y365_ff <= y365_in;
         q4_ff   <= q4_in;
         q100_ff <= q100_in;
         mday_ff <= mday_in;
         hms_ff  <= hms_in;
      end
      if (state_ff == BK_DAYS) begin
         days_ff <= days_in;
      end
      if (state_ff == BK_SCALE) begin
         epoch_ff <= epoch_in;
      end
      if (load_out) begin
         rsp_chan.power_enable     <= job_ff.power_enable;
         rsp_chan.power_event      <= job_ff.power_event;
         rsp_chan.clock_set        <= job_ff.clock_set;
         rsp_chan.epoch_seconds    <= job_ff.clock_set ? epoch_ff : '0;
         rsp_chan.location_capture <= job_ff.location_capture;
      end
   end

   assign rsp_chan.valid = out_valid_ff;

endmodule

`default_nettype wire

[hw/rtl/gnss_power_duty_cycler_unit.sv]
// GNSS receiver power duty cycler: one response per millisecond tick, with the power
// decision, a debounced clock-set carrying Unix seconds, and the location capture pulse.
// The front end decides power, sync and capture for a tick in the cycle it is accepted and
// queues it; the back end drains the queue one tick at a time. A tick without a clock-set
// passes from idle straight to the response stage, while a tick with one first steps through
// year split, divide by 100, day sum and multiply by 86400, then waits to hand over its response.
// Ticks keep being accepted while the queue has room, including while a response waits.
// Config writes take effect on the next tick; write them only while no tick is in flight.
// Depends on gpdc_pkg, gpdc_if, gpdc_front, gpdc_queue and gpdc_back.
`default_nettype none

module gnss_power_duty_cycler_unit #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   gpdc_req_if.sink                              req_chan,
   gpdc_rsp_if.source                            rsp_chan,
   input  wire logic                             csr_write_enable,
   input  wire logic [gpdc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [gpdc_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import gpdc_pkg::*;

   queue_status_type q_status;
   job_type          push_job, pop_job;
   logic             push, pop;

   gpdc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .q_status         (q_status),
      .push             (push),
      .push_job         (push_job)
   );

   gpdc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .status   (q_status)
   );

   gpdc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .pop_job  (pop_job),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

`ifndef SYNTHESIS
   a_epoch_only_with_set: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.clock_set |-> rsp_chan.epoch_seconds == '0)
      else $error("epoch seconds without clock set");

   a_woke_is_on: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.power_event == EV_WOKE |-> rsp_chan.power_enable)
      else $error("wake event with power off");

   a_off_event_is_off: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.power_event == EV_OFF_LOCATED
         || rsp_chan.power_event == EV_OFF_TIMEOUT
         || rsp_chan.power_event == EV_OFF_SYNCED) |-> !rsp_chan.power_enable)
      else $error("power-off event with power on");

   a_actions_need_power: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.clock_set || rsp_chan.location_capture)
         |-> rsp_chan.power_enable)
      else $error("clock set or capture while unpowered");

   a_queue_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire
